// ===== rtl/mtf_pkg.sv =====
// shared widths for the move-to-front count table
`default_nettype none

package mtf_pkg;

    // payload widths of the two channels
    localparam int KEY_W   = 32;
    localparam int POS_W   = 4;
    localparam int TALLY_W = 16;

    // width used to carry an index or a count before trimming to a port
    localparam int EXT_W   = 32;

    // operation codes on the func field
    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // request from the sequencer to the table storage
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_store_req;

endpackage

`default_nettype wire

// ===== rtl/mtf_store.sv =====
// key and count storage with registered read and per-entry valid bits
`default_nettype none

module mtf_store #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16,
    parameter int IDX_W      = $clog2(ENTRIES)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mtf_pkg::t_store_req        i_req,
    input  wire logic [IDX_W-1:0]           i_rd_addr,
    input  wire logic [IDX_W-1:0]           i_wr_addr,
    input  wire logic [mtf_pkg::KEY_W-1:0]  i_wr_key,
    input  wire logic [COUNT_BITS-1:0]      i_wr_count,
    output logic      [mtf_pkg::KEY_W-1:0]  o_rd_key,
    output logic      [COUNT_BITS-1:0]      o_rd_count
);
    import mtf_pkg::*;

    logic [KEY_W-1:0]      r_key_mem [ENTRIES];
    logic [COUNT_BITS-1:0] r_cnt_mem [ENTRIES];
    logic [ENTRIES-1:0]    r_vld;
    logic [KEY_W-1:0]      r_rd_key;
    logic [COUNT_BITS-1:0] r_rd_cnt;
    logic                  r_rd_vld;

    // memory write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
            r_cnt_mem[i_wr_addr] <= i_wr_count;
        end
    end

    // valid bits, cleared at reset so untouched entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_key <= r_key_mem[i_rd_addr];
            r_rd_cnt <= r_cnt_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_req.rd_en) begin
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    // an entry never written reads as key zero, count zero
    assign o_rd_key   = r_rd_vld ? r_rd_key : '0;
    assign o_rd_count = r_rd_vld ? r_rd_cnt : '0;

endmodule

`default_nettype wire

// ===== rtl/mtf_unit.sv =====
// shared key compare and saturating count increment
`default_nettype none

module mtf_unit #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic [mtf_pkg::KEY_W-1:0] i_key_a,
    input  wire logic [mtf_pkg::KEY_W-1:0] i_key_b,
    input  wire logic [COUNT_BITS-1:0]     i_count,
    output logic                           o_match,
    output logic      [COUNT_BITS-1:0]     o_count_inc
);
    import mtf_pkg::*;

    // key equality
    assign o_match = (i_key_a == i_key_b);

    // increment that holds at the top value
    assign o_count_inc = (&i_count) ? i_count : i_count + COUNT_BITS'(1);

endmodule

`default_nettype wire

// ===== rtl/move_to_front_count_table_core.sv =====
// move-to-front count table: sequencer, table storage and shared unit
//
// Input channel: i_valid / o_stall carry func and key. Output channel:
// o_valid / i_stall carry found, position and tally. A transfer happens
// on a rising edge with valid high and stall low.
// Each item gives exactly one result. The table is walked one entry per
// cycle through a single read port and one shared compare unit:
//   lookup: scan to the key or the last entry, then load the result
//   record: the same scan, then each entry ahead of the key (all but
//           the last when the key is absent) moves back one place,
//           the key and its new count go to the front, the result loads
// The scan and the shift share the table's one read and one write port.
// o_stall is high while an item is in work.
// The result sits in an output register; a new item may be taken while
// it waits, but that item's result is held until the register is free.
// A held result does not change while i_stall is high.
// Reset (i_rst_n low, synchronous) empties the output register and marks
// every table entry as key 0 with count 0, at once, with no clearing pass.
`default_nettype none

module move_to_front_count_table_core #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_func,
    input  wire logic [mtf_pkg::KEY_W-1:0]     i_key,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_found,
    output logic      [mtf_pkg::POS_W-1:0]     o_position,
    output logic      [mtf_pkg::TALLY_W-1:0]   o_tally
);
    import mtf_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_TWO  = IDX_W'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FRONT,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic                  r_func, n_func;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_pos, n_pos;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_found, n_out_found;
    logic [POS_W-1:0]      r_out_pos, n_out_pos;
    logic [TALLY_W-1:0]    r_out_tally, n_out_tally;

    t_store_req            w_req;
    logic [IDX_W-1:0]      w_rd_addr;
    logic [IDX_W-1:0]      w_wr_addr;
    logic [KEY_W-1:0]      w_wr_key;
    logic [COUNT_BITS-1:0] w_wr_count;
    logic [KEY_W-1:0]      w_rd_key;
    logic [COUNT_BITS-1:0] w_rd_count;
    logic                  w_match;
    logic [COUNT_BITS-1:0] w_count_inc;
    logic [EXT_W-1:0]      w_pos_ext;
    logic [EXT_W-1:0]      w_cnt_ext;
    logic                  w_in_xfer;
    logic                  w_out_free;

    // table storage
    mtf_store #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_rd_addr  (w_rd_addr),
        .i_wr_addr  (w_wr_addr),
        .i_wr_key   (w_wr_key),
        .i_wr_count (w_wr_count),
        .o_rd_key   (w_rd_key),
        .o_rd_count (w_rd_count)
    );

    // compare and increment used by the scan
    mtf_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_unit (
        .i_key_a     (r_key),
        .i_key_b     (w_rd_key),
        .i_count     (w_rd_count),
        .o_match     (w_match),
        .o_count_inc (w_count_inc)
    );

    assign w_in_xfer  = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_pos_ext  = EXT_W'(r_pos);
    assign w_cnt_ext  = EXT_W'(r_cnt);

    // sequencer next state and storage requests
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_key       = r_key;
        n_idx       = r_idx;
        n_found     = r_found;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_pos   = r_out_pos;
        n_out_tally = r_out_tally;
        w_req       = '0;
        w_rd_addr   = '0;
        w_wr_addr   = r_idx;
        w_wr_key    = w_rd_key;
        w_wr_count  = w_rd_count;

        // output register drains on a transfer
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_func      = i_func;
                    n_key       = i_key;
                    n_idx       = '0;
                    w_req.rd_en = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    n_found = 1'b1;
                    n_pos   = r_idx;
                    if (r_func == FUNC_LOOKUP) begin
                        n_cnt   = w_rd_count;
                        n_state = S_DONE;
                    end else begin
                        n_cnt = w_count_inc;
                        if (r_idx == '0) begin
                            n_state = S_FRONT;
                        end else begin
                            w_req.rd_en = 1'b1;
                            w_rd_addr   = r_idx - IDX_ONE;
                            n_state     = S_SHIFT;
                        end
                    end
                end else if (r_idx == IDX_LAST) begin
                    n_found = 1'b0;
                    n_pos   = '0;
                    if (r_func == FUNC_LOOKUP) begin
                        n_cnt   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_cnt       = COUNT_BITS'(1);
                        w_req.rd_en = 1'b1;
                        w_rd_addr   = IDX_LAST - IDX_ONE;
                        n_state     = S_SHIFT;
                    end
                end else begin
                    w_req.rd_en = 1'b1;
                    w_rd_addr   = r_idx + IDX_ONE;
                    n_idx       = r_idx + IDX_ONE;
                end
            end
            S_SHIFT: begin
                // entry below moves back one place
                w_req.wr_en = 1'b1;
                if (r_idx == IDX_ONE) begin
                    n_state = S_FRONT;
                end else begin
                    w_req.rd_en = 1'b1;
                    w_rd_addr   = r_idx - IDX_TWO;
                    n_idx       = r_idx - IDX_ONE;
                end
            end
            S_FRONT: begin
                w_req.wr_en = 1'b1;
                w_wr_addr   = '0;
                w_wr_key    = r_key;
                w_wr_count  = r_cnt;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_pos   = w_pos_ext[POS_W-1:0];
                    n_out_tally = w_cnt_ext[TALLY_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_func      <= n_func;
        r_key       <= n_key;
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_pos       <= n_pos;
        r_cnt       <= n_cnt;
        r_out_found <= n_out_found;
        r_out_pos   <= n_out_pos;
        r_out_tally <= n_out_tally;
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_found    = r_out_found;
    assign o_position = r_out_pos;
    assign o_tally    = r_out_tally;

endmodule

`default_nettype wire

// ===== rtl/mtf_checker.sv =====
// port-level checks for the move-to-front count table, bound to the top level
`default_nettype none

module mtf_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_valid,
    input wire logic                        o_stall,
    input wire logic                        i_func,
    input wire logic [mtf_pkg::KEY_W-1:0]   i_key,
    input wire logic                        o_valid,
    input wire logic                        i_stall,
    input wire logic                        o_found,
    input wire logic [mtf_pkg::POS_W-1:0]   o_position,
    input wire logic [mtf_pkg::TALLY_W-1:0] o_tally
);
    import mtf_pkg::*;

    // reset leaves the block empty and ready
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("block not empty after reset");

    // an accepted item holds off the next one: o_stall is high in the following cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while previous item still in work");

    // a held result keeps its fields
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_found)
            && $stable(o_position) && $stable(o_tally)))
        else $error("stalled result changed");

    // an absent key reports position zero and a tally of zero or one
    a_absent_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_position == '0
            && (o_tally == TALLY_W'(0) || o_tally == TALLY_W'(1))))
        else $error("absent key with bad position or tally");

endmodule

bind move_to_front_count_table_core mtf_checker u_mtf_checker (.*);

`default_nettype wire

// ===== test/tb_move_to_front_count_table_core.sv =====
// testbench for the move-to-front count table core
`timescale 1ns / 100ps

module tb_move_to_front_count_table_core;

    import mtf_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int COUNT_BITS   = 16;
    localparam int MAX_WAIT     = 12;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;
    localparam int REPEAT_ITEMS = 200;
    localparam int RANDOM_ITEMS = 1400;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic [TALLY_W-1:0] tally;
    } t_table_result;

    // block ports
    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic               i_func     = FUNC_RECORD;
    logic [KEY_W-1:0]   i_key      = '0;
    logic               i_stall    = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic               o_found;
    logic [POS_W-1:0]   o_position;
    logic [TALLY_W-1:0] o_tally;

    // mirror of the table, most recent key at index 0
    logic [KEY_W-1:0]      mtf_keys   [ENTRIES];
    logic [COUNT_BITS-1:0] mtf_counts [ENTRIES];

    t_table_result pending_results[$];

    bit send_idle    = 1'b1;
    bit recv_idle    = 1'b1;
    int error_count  = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    move_to_front_count_table_core #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_func     (i_func),
        .i_key      (i_key),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_found    (o_found),
        .o_position (o_position),
        .o_tally    (o_tally)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int draw_wait(input bit enabled);
        return enabled ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    // expected result of one item, updates the mirror
    function automatic t_table_result predict_table_item(input logic func,
                                                         input logic [KEY_W-1:0] key);
        int                    hit;
        logic [COUNT_BITS-1:0] cnt;
        t_table_result         res;
        int                    last;
        hit = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && mtf_keys[i] == key) hit = i;
        end
        res.found    = (hit >= 0);
        res.position = (hit >= 0) ? hit[POS_W-1:0] : '0;
        res.tally    = '0;
        if (func == FUNC_LOOKUP) begin
            if (hit >= 0) res.tally = TALLY_W'(mtf_counts[hit]);
        end else begin
            // on a hit the entry leaves its slot, on a miss the last one drops
            if (hit >= 0) begin
                cnt  = mtf_counts[hit];
                last = hit;
                if (cnt != COUNT_MAX) cnt = cnt + 1'b1;
            end else begin
                cnt  = COUNT_BITS'(1);
                last = ENTRIES - 1;
            end
            for (int j = last; j > 0; j--) begin
                mtf_keys[j]   = mtf_keys[j-1];
                mtf_counts[j] = mtf_counts[j-1];
            end
            mtf_keys[0]   = key;
            mtf_counts[0] = cnt;
            res.tally     = TALLY_W'(cnt);
        end
        return res;
    endfunction

    // one input transfer, expectation queued once it is taken
    task automatic send_item(input logic func, input logic [KEY_W-1:0] key);
        int gap;
        gap = draw_wait(send_idle);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= func;
        i_key   <= key;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_table_item(func, key));
    endtask

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // result side: random stall after each transfer, check against the oldest expectation
    always @(posedge i_clk) begin
        t_table_result want;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t unexpected result: expected none actual found %0d position %0d tally %0d",
                             $time, o_found, o_position, o_tally);
                end else begin
                    want = pending_results.pop_front();
                    report_field("found", want.found, o_found);
                    report_field("position", want.position, o_position);
                    report_field("tally", want.tally, o_tally);
                end
                hold_left = draw_wait(recv_idle);
            end else if (o_valid && hold_left > 0) begin
                hold_left--;
            end
            i_stall <= (hold_left > 0);
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("FAIL move_to_front_count_table_core");
                $finish;
            end
        end
    end

    // key zero against cleared entries, absent keys
    task automatic test_cleared_table();
        send_item(FUNC_LOOKUP, '0);
        send_item(FUNC_LOOKUP, '1);
        send_item(FUNC_RECORD, '0);
        send_item(FUNC_RECORD, '1);
        send_item(FUNC_LOOKUP, '0);
    endtask

    // fill every slot, hit the deepest slot, evict the last entry
    task automatic test_fill_and_evict();
        for (int i = 0; i < ENTRIES - 2; i++) send_item(FUNC_RECORD, 32'h8000_0000 >> i);
        send_item(FUNC_LOOKUP, '0);
        send_item(FUNC_RECORD, '0);
        send_item(FUNC_LOOKUP, '1);
        send_item(FUNC_RECORD, 32'h5555_5555);
        send_item(FUNC_LOOKUP, '1);
        send_item(FUNC_RECORD, 32'hAAAA_AAAA);
    endtask

    // one key recorded back to back, its count climbing at the front
    task automatic test_repeated_count();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        for (int n = 0; n < REPEAT_ITEMS; n++) send_item(FUNC_RECORD, 32'h1234_5678);
        send_item(FUNC_LOOKUP, 32'h1234_5678);
    endtask

    // mostly keys from a small pool so hits, moves and evictions all happen
    task automatic test_random_traffic(input int n_items);
        logic [KEY_W-1:0] pool [40];
        int               pool_size;
        int               pick;
        logic             func;
        logic [KEY_W-1:0] key;
        pool_size = 8;
        for (int p = 0; p < 40; p++) pool[p] = $urandom;
        for (int n = 0; n < n_items; n++) begin
            if (n % 200 == 0) begin
                pool_size = $urandom_range(4, 40);
                send_idle = ($urandom_range(0, 3) != 0);
                recv_idle = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)
                key = pool[$urandom_range(0, pool_size - 1)];
            else if (pick < 80)
                key = '0;
            else
                key = $urandom;
            func = ($urandom_range(0, 99) < 40) ? FUNC_LOOKUP : FUNC_RECORD;
            send_item(func, key);
        end
    endtask

    // wait for every expected result, then let the block settle
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            mtf_keys[i]   = '0;
            mtf_counts[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_cleared_table();
        test_fill_and_evict();
        test_repeated_count();
        test_random_traffic(RANDOM_ITEMS);
        drain_results();

        if (error_count == 0)
            $display("PASS move_to_front_count_table_core");
        else
            $display("FAIL move_to_front_count_table_core");
        $finish;
    end

endmodule
